// File: hdl/jls_pkg.sv
package jls_pkg;

  localparam int MAX_UNKNOWNS = 8;
  localparam int COLS         = MAX_UNKNOWNS + 1;
  localparam int VAL_W        = 48;
  localparam int HALF_W       = 25;
  localparam int PROD_W       = 2 * HALF_W;
  localparam int ACC_W        = 100;
  localparam int SUM_W        = 51;
  localparam int ROW_W        = 3;
  localparam int CNT_W        = 4;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  localparam logic [1:0] REG_SYSTEM_SIZE = 2'd0;
  localparam logic [1:0] REG_TOLERANCE   = 2'd1;
  localparam logic [1:0] REG_ITER_LIMIT  = 2'd2;

  localparam logic [1:0] STATUS_CONVERGED  = 2'd0;
  localparam logic [1:0] STATUS_LIMIT      = 2'd1;
  localparam logic [1:0] STATUS_ZERO_PIVOT = 2'd2;

  function automatic logic [VAL_W-1:0] mag(input logic [VAL_W-1:0] v);
    mag = v[VAL_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// File: hdl/jacobi_linear_solver_unit.sv
// channel   direction  ports                                           transfer when
// ------    ---------  ----------------------------------------------  ---------------------
// input     in         start, busy, in_row_index .. in_load_done       start high, busy low
// result    out        out_valid, out_unknown_index .. out_last_result out_valid high
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data       cfg_valid and cfg_ready
//
// elements load one per cycle while not busy; the element with load_done starts the solve
// solve: reorder scan (a row that is not diagonally dominant is swapped, column by column,
// with the first later row dominant in its column), pivot check, then Jacobi sweeps on the
// shared 25x25 multiplier, which forms each product term and squared difference, and the
// bit-serial divider (saturating), one division a row; then n results, one a cycle
// synchronous active-low reset; results cannot be stalled, busy is low once the last
// result is presented, and cfg_ready is always high
module jacobi_linear_solver_unit #(
  parameter int FRACTION_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        in_row_index,
  input  logic [3:0]                        in_column_index,
  input  logic signed [47:0]                in_element_value,
  input  logic                              in_load_done,
  output logic                              out_valid,
  output logic [2:0]                        out_unknown_index,
  output logic signed [47:0]                out_solution_value,
  output logic [15:0]                       out_sweep_count,
  output logic [1:0]                        out_status,
  output logic                              out_reorder_failed,
  output logic                              out_last_result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [63:0]                       cfg_data
);

  localparam int VW   = jls_pkg::VAL_W;
  localparam int AW   = jls_pkg::ACC_W;
  localparam int HW   = jls_pkg::HALF_W;
  localparam int CW   = jls_pkg::CNT_W;
  localparam int MU   = jls_pkg::MAX_UNKNOWNS;
  localparam int TSHL = (2 * FRACTION_BITS >= 64) ? 2 * FRACTION_BITS - 64 : 0;
  localparam int TSHR = (2 * FRACTION_BITS >= 64) ? 0 : 64 - 2 * FRACTION_BITS;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SC_RD, ST_SC_ACC, ST_RO_EVAL, ST_SW_A, ST_SW_B, ST_SW_C, ST_SW_D,
    ST_PV_RD, ST_PV_CHK, ST_SWP_START, ST_RB_RD, ST_RB_LD, ST_PR_CHK, ST_PR_RD,
    ST_PR_OPS, ST_MUL, ST_MACC, ST_DV_RD, ST_DV_GO, ST_DV_WAIT, ST_SQ_OPS,
    ST_SWP_END, ST_OUT
  } state_t;

  state_t                       state_r;
  logic [3:0]                   sys_size_r;
  logic [63:0]                  tol_r;
  logic [15:0]                  lim_r;
  logic [CW-1:0]                n_r;
  logic [15:0]                  limit_r;
  logic [CW-1:0]                row_r;
  logic [CW-1:0]                cand_r;
  logic [CW-1:0]                col_r;
  logic                         cand_mode_r;
  logic                         failed_r;
  logic                         zp_r;
  logic [jls_pkg::SUM_W-1:0]    sum_r;
  logic [VW-1:0]                diag_r;
  logic [VW-1:0]                tmp_r;
  logic [AW-1:0]                acc_r;
  logic [AW-1:0]                ssq_r;
  logic [jls_pkg::PROD_W-1:0]   opa_r;
  logic [jls_pkg::PROD_W-1:0]   opb_r;
  logic                         neg_r;
  logic                         ssq_mode_r;
  logic [1:0]                   k_r;
  logic signed [VW-1:0]         newv_r;
  logic [15:0]                  cnt_r;
  logic [1:0]                   status_r;
  logic signed [VW-1:0]         cur_r  [MU];
  logic signed [VW-1:0]         prev_r [MU];

  logic [VW-1:0]                mem_r  [MU][jls_pkg::COLS];
  logic [VW-1:0]                mem_q_r;
  logic [CW-1:0]                rd_row, rd_col, wr_row, wr_col;
  logic [VW-1:0]                wr_data;
  logic                         mem_we;

  logic                         out_valid_r, out_last_r, out_failed_r;
  logic [2:0]                   out_idx_r;
  logic signed [VW-1:0]         out_val_r;
  logic [15:0]                  out_cnt_r;
  logic [1:0]                   out_status_r;

  logic [HW-1:0]                mul_a, mul_b;
  logic [jls_pkg::PROD_W-1:0]   prod;
  logic                         div_start, div_done;
  logic signed [VW-1:0]         div_q;
  logic [AW-1:0]                term, tol_s;
  logic [CW-1:0]                prev_idx;
  logic [VW:0]                  diff;
  logic [VW:0]                  dmag;
  logic [VW-1:0]                rd_mag;
  logic [15:0]                  cnt_nxt;
  logic                         accept;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_size_r <= 4'd3;
      tol_r      <= 64'd18446744;
      lim_r      <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jls_pkg::REG_SYSTEM_SIZE: sys_size_r <= cfg_data[3:0];
        jls_pkg::REG_TOLERANCE:   tol_r      <= cfg_data;
        jls_pkg::REG_ITER_LIMIT:  lim_r      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rd_row = '0;
    rd_col = '0;
    unique case (state_r)
      ST_SC_RD: begin rd_row = cand_mode_r ? cand_r : row_r; rd_col = col_r; end
      ST_SW_A:  begin rd_row = row_r;  rd_col = col_r; end
      ST_SW_B:  begin rd_row = cand_r; rd_col = col_r; end
      ST_PV_RD: begin rd_row = col_r;  rd_col = col_r; end
      ST_RB_RD: begin rd_row = row_r;  rd_col = n_r;   end
      ST_PR_RD: begin rd_row = row_r;  rd_col = col_r; end
      ST_DV_RD: begin rd_row = row_r;  rd_col = row_r; end
      default: ;
    endcase
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_row  = '0;
    wr_col  = '0;
    wr_data = mem_q_r;
    priority if (accept) begin
      mem_we  = (in_column_index <= CW'(jls_pkg::COLS - 1));
      wr_row  = CW'(in_row_index);
      wr_col  = in_column_index;
      wr_data = in_element_value;
    end else if (state_r == ST_SW_C) begin
      mem_we = 1'b1;
      wr_row = row_r;
      wr_col = col_r;
    end else if (state_r == ST_SW_D) begin
      mem_we  = 1'b1;
      wr_row  = cand_r;
      wr_col  = col_r;
      wr_data = tmp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[wr_row[2:0]][wr_col] <= wr_data;
    mem_q_r <= mem_r[rd_row[2:0]][rd_col];
  end

  assign mul_a = k_r[0] ? opa_r[2*HW-1:HW] : opa_r[HW-1:0];
  assign mul_b = k_r[1] ? opb_r[2*HW-1:HW] : opb_r[HW-1:0];

  jls_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign div_start = (state_r == ST_DV_GO);

  jls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r),
    .den   (mem_q_r),
    .done  (div_done),
    .q     (div_q)
  );

  always_comb begin
    unique case (k_r)
      2'd0:    term = AW'(prod);
      2'd1,
      2'd2:    term = AW'(prod) << HW;
      default: term = AW'(prod) << (2 * HW);
    endcase
  end

  assign tol_s    = (AW'(tol_r) << TSHL) >> TSHR;
  assign prev_idx = (state_r == ST_SQ_OPS) ? row_r : col_r;
  assign diff     = {prev_r[prev_idx[2:0]][VW-1], prev_r[prev_idx[2:0]]}
                    - {newv_r[VW-1], newv_r};
  assign dmag     = diff[VW] ? (~diff + 1'b1) : diff;
  assign rd_mag   = jls_pkg::mag(mem_q_r);
  assign cnt_nxt  = cnt_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept && in_load_done) begin
            n_r         <= (sys_size_r == 4'd0) ? CW'(1) :
                           ((sys_size_r > 4'(MU)) ? CW'(MU) : sys_size_r);
            limit_r     <= (lim_r == 16'd0) ? 16'd1 : lim_r;
            row_r       <= '0;
            col_r       <= '0;
            sum_r       <= '0;
            cand_mode_r <= 1'b0;
            failed_r    <= 1'b0;
            cnt_r       <= '0;
            for (int j = 0; j < MU; j++) cur_r[j] <= '0;
            state_r     <= ST_SC_RD;
          end
        end
        ST_SC_RD: state_r <= ST_SC_ACC;
        ST_SC_ACC: begin
          if (col_r == row_r) diag_r <= rd_mag;
          else sum_r <= sum_r + jls_pkg::SUM_W'(rd_mag);
          if (col_r == n_r - CW'(1)) begin
            state_r <= ST_RO_EVAL;
          end else begin
            col_r   <= col_r + CW'(1);
            state_r <= ST_SC_RD;
          end
        end
        ST_RO_EVAL: begin
          col_r <= '0;
          sum_r <= '0;
          if (!cand_mode_r) begin
            if (sum_r > jls_pkg::SUM_W'(diag_r)) begin
              if (row_r + CW'(1) >= n_r) begin
                failed_r <= 1'b1;
                state_r  <= ST_PV_RD;
              end else begin
                cand_r      <= row_r + CW'(1);
                cand_mode_r <= 1'b1;
                state_r     <= ST_SC_RD;
              end
            end else if (row_r + CW'(1) == n_r) begin
              state_r <= ST_PV_RD;
            end else begin
              row_r   <= row_r + CW'(1);
              state_r <= ST_SC_RD;
            end
          end else begin
            if (jls_pkg::SUM_W'(diag_r) >= sum_r) begin
              state_r <= ST_SW_A;
            end else if (cand_r + CW'(1) >= n_r) begin
              failed_r <= 1'b1;
              state_r  <= ST_PV_RD;
            end else begin
              cand_r  <= cand_r + CW'(1);
              state_r <= ST_SC_RD;
            end
          end
          zp_r <= 1'b0;
        end
        ST_SW_A: state_r <= ST_SW_B;
        ST_SW_B: begin
          tmp_r   <= mem_q_r;
          state_r <= ST_SW_C;
        end
        ST_SW_C: state_r <= ST_SW_D;
        ST_SW_D: begin
          if (col_r == n_r) begin
            col_r       <= '0;
            sum_r       <= '0;
            cand_mode_r <= 1'b0;
            if (row_r + CW'(1) == n_r) begin
              state_r <= ST_PV_RD;
            end else begin
              row_r   <= row_r + CW'(1);
              state_r <= ST_SC_RD;
            end
          end else begin
            col_r   <= col_r + CW'(1);
            state_r <= ST_SW_A;
          end
        end
        ST_PV_RD: state_r <= ST_PV_CHK;
        ST_PV_CHK: begin
          if (col_r == n_r - CW'(1)) begin
            col_r <= '0;
            if (zp_r || mem_q_r == '0) begin
              status_r <= jls_pkg::STATUS_ZERO_PIVOT;
              state_r  <= ST_OUT;
            end else begin
              state_r <= ST_SWP_START;
            end
          end else begin
            if (mem_q_r == '0) zp_r <= 1'b1;
            col_r   <= col_r + CW'(1);
            state_r <= ST_PV_RD;
          end
        end
        ST_SWP_START: begin
          for (int j = 0; j < MU; j++) prev_r[j] <= cur_r[j];
          ssq_r   <= '0;
          row_r   <= '0;
          state_r <= ST_RB_RD;
        end
        ST_RB_RD: state_r <= ST_RB_LD;
        ST_RB_LD: begin
          acc_r   <= {{(AW-VW){mem_q_r[VW-1]}}, mem_q_r} << FRACTION_BITS;
          col_r   <= '0;
          state_r <= ST_PR_CHK;
        end
        ST_PR_CHK: begin
          if (col_r == n_r) state_r <= ST_DV_RD;
          else if (col_r == row_r) col_r <= col_r + CW'(1);
          else state_r <= ST_PR_RD;
        end
        ST_PR_RD: state_r <= ST_PR_OPS;
        ST_PR_OPS: begin
          opa_r      <= jls_pkg::PROD_W'(rd_mag);
          opb_r      <= jls_pkg::PROD_W'(jls_pkg::mag(prev_r[prev_idx[2:0]]));
          neg_r      <= mem_q_r[VW-1] ^ prev_r[prev_idx[2:0]][VW-1];
          ssq_mode_r <= 1'b0;
          k_r        <= '0;
          state_r    <= ST_MUL;
        end
        ST_MUL: state_r <= ST_MACC;
        ST_MACC: begin
          if (ssq_mode_r) ssq_r <= ssq_r + term;
          else if (neg_r) acc_r <= acc_r + term;
          else acc_r <= acc_r - term;
          if (k_r == 2'd3) begin
            if (ssq_mode_r) begin
              if (row_r + CW'(1) == n_r) begin
                state_r <= ST_SWP_END;
              end else begin
                row_r   <= row_r + CW'(1);
                state_r <= ST_RB_RD;
              end
            end else begin
              col_r   <= col_r + CW'(1);
              state_r <= ST_PR_CHK;
            end
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= ST_MUL;
          end
        end
        ST_DV_RD: state_r <= ST_DV_GO;
        ST_DV_GO: state_r <= ST_DV_WAIT;
        ST_DV_WAIT: begin
          if (div_done) begin
            newv_r  <= div_q;
            state_r <= ST_SQ_OPS;
          end
        end
        ST_SQ_OPS: begin
          opa_r             <= jls_pkg::PROD_W'(dmag);
          opb_r             <= jls_pkg::PROD_W'(dmag);
          ssq_mode_r        <= 1'b1;
          k_r               <= '0;
          cur_r[row_r[2:0]] <= newv_r;
          state_r           <= ST_MUL;
        end
        ST_SWP_END: begin
          cnt_r <= cnt_nxt;
          col_r <= '0;
          priority if (ssq_r <= tol_s) begin
            status_r <= jls_pkg::STATUS_CONVERGED;
            state_r  <= ST_OUT;
          end else if (cnt_nxt >= limit_r) begin
            status_r <= jls_pkg::STATUS_LIMIT;
            state_r  <= ST_OUT;
          end else begin
            state_r <= ST_SWP_START;
          end
        end
        ST_OUT: begin
          out_valid_r  <= 1'b1;
          out_idx_r    <= col_r[2:0];
          out_val_r    <= cur_r[col_r[2:0]];
          out_cnt_r    <= cnt_r;
          out_status_r <= status_r;
          out_failed_r <= failed_r;
          out_last_r   <= (col_r == n_r - CW'(1));
          if (col_r == n_r - CW'(1)) state_r <= ST_IDLE;
          else col_r <= col_r + CW'(1);
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_unknown_index  = out_idx_r;
  assign out_solution_value = out_val_r;
  assign out_sweep_count    = out_cnt_r;
  assign out_status         = out_status_r;
  assign out_reorder_failed = out_failed_r;
  assign out_last_result    = out_last_r;

  a_last_ends_burst : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |=> !out_valid)
    else $error("result strobe after last result");

  a_burst_contiguous : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |=> out_valid)
    else $error("gap inside result burst");

  a_solve_starts : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_load_done |=> busy)
    else $error("solve did not start");

  a_div_done_waited : assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DV_WAIT)
    else $error("divider finished outside its wait state");

endmodule

// File: hdl/jls_mul.sv
module jls_mul (
  input  logic                        clk,
  input  logic [jls_pkg::HALF_W-1:0]  a,
  input  logic [jls_pkg::HALF_W-1:0]  b,
  output logic [jls_pkg::PROD_W-1:0]  p
);

  logic [jls_pkg::PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= jls_pkg::PROD_W'(a) * jls_pkg::PROD_W'(b);
  end

  assign p = p_r;

endmodule

// File: hdl/jls_div.sv
module jls_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [jls_pkg::ACC_W-1:0]         num,
  input  logic [jls_pkg::VAL_W-1:0]         den,
  output logic                              done,
  output logic signed [jls_pkg::VAL_W-1:0]  q
);

  typedef enum logic [1:0] {D_IDLE, D_CHK, D_RUN, D_FIN} dstate_t;

  dstate_t                        state_r;
  logic [jls_pkg::ACC_W-1:0]      rem_r;
  logic [jls_pkg::ACC_W-1:0]      dsh_r;
  logic [jls_pkg::VAL_W-1:0]      quo_r;
  logic [5:0]                     bit_r;
  logic                           neg_r;
  logic                           done_r;
  logic signed [jls_pkg::VAL_W-1:0] q_r;
  logic                           ge;

  assign ge = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            neg_r   <= num[jls_pkg::ACC_W-1] ^ den[jls_pkg::VAL_W-1];
            rem_r   <= num[jls_pkg::ACC_W-1] ? (~num + 1'b1) : num;
            dsh_r   <= jls_pkg::ACC_W'(jls_pkg::mag(den)) << jls_pkg::VAL_W;
            state_r <= D_CHK;
          end
        end
        D_CHK: begin
          if (ge) begin
            quo_r   <= '1;
            state_r <= D_FIN;
          end else begin
            quo_r   <= '0;
            dsh_r   <= dsh_r >> 1;
            bit_r   <= 6'(jls_pkg::VAL_W - 1);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          if (ge) rem_r <= rem_r - dsh_r;
          quo_r <= {quo_r[jls_pkg::VAL_W-2:0], ge};
          dsh_r <= dsh_r >> 1;
          if (bit_r == 6'd0) state_r <= D_FIN;
          else bit_r <= bit_r - 6'd1;
        end
        D_FIN: begin
          if (neg_r) q_r <= quo_r[jls_pkg::VAL_W-1] ? jls_pkg::VAL_MIN : -quo_r;
          else       q_r <= quo_r[jls_pkg::VAL_W-1] ? jls_pkg::VAL_MAX : quo_r;
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  VAL_W        = jls_pkg::VAL_W;
  localparam int  MAX_UNKNOWNS = jls_pkg::MAX_UNKNOWNS;
  localparam int  COLS         = jls_pkg::COLS;

  localparam int  SETTLE_CYCLES = 64;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef struct {
    logic [2:0]               idx;
    logic signed [VAL_W-1:0]  val;
    logic [15:0]              sweeps;
    logic [1:0]               st;
    logic                     failed;
    logic                     last;
  } unknown_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_row_index = '0;
  logic [3:0] in_column_index = '0;
  logic signed [47:0] in_element_value = '0;
  logic in_load_done = 1'b0;
  logic out_valid;
  logic [2:0] out_unknown_index;
  logic signed [47:0] out_solution_value;
  logic [15:0] out_sweep_count;
  logic [1:0] out_status;
  logic out_reorder_failed;
  logic out_last_result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // predictor state
  logic signed [VAL_W-1:0] mat [0:MAX_UNKNOWNS-1][0:COLS-1];
  logic [3:0]  size_reg = 4'd3;
  logic [63:0] tol_reg = 64'd18446744;
  logic [15:0] limit_reg = 16'd1000;

  unknown_t solution_q[$];
  int errors = 0;
  int items_sent = 0;
  int solves = 0;
  int results_seen = 0;
  int gap_pct = 0;
  longint cycles = 0;

  jacobi_linear_solver_unit u_top (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic logic [63:0] absv(logic signed [VAL_W-1:0] v);
    logic signed [63:0] w;
    w = v;
    return w < 0 ? -w : w;
  endfunction

  function automatic logic [63:0] off_mag(int r, int skip, int n);
    logic [63:0] s;
    s = '0;
    for (int c = 0; c < n; c++) if (c != skip) s += absv(mat[r][c]);
    return s;
  endfunction

  function automatic void solve_system();
    int n;
    int lim;
    int sweeps;
    logic failed;
    logic zp;
    logic dom;
    logic found;
    logic [1:0] st;
    logic signed [VAL_W-1:0] cur [0:MAX_UNKNOWNS-1];
    logic signed [VAL_W-1:0] prv [0:MAX_UNKNOWNS-1];
    logic signed [VAL_W-1:0] t;
    logic signed [127:0] acc, num, den, q;
    logic signed [63:0] diff;
    logic [63:0] d;
    logic [127:0] ssq;
    unknown_t u;
    n = size_reg == 0 ? 1 : (size_reg > MAX_UNKNOWNS ? MAX_UNKNOWNS : size_reg);
    lim = limit_reg == 0 ? 1 : limit_reg;
    dom = 1'b1;
    for (int r = 0; r < n; r++) if (absv(mat[r][r]) <= off_mag(r, r, n)) dom = 1'b0;
    failed = 1'b0;
    if (!dom) begin
      for (int r = 0; r < n && !failed; r++) begin
        if (off_mag(r, r, n) > absv(mat[r][r])) begin
          found = 1'b0;
          for (int i = r + 1; i < n && !found; i++) begin
            if (absv(mat[i][r]) >= off_mag(i, r, n)) begin
              for (int c = 0; c <= n; c++) begin
                t = mat[r][c];
                mat[r][c] = mat[i][c];
                mat[i][c] = t;
              end
              found = 1'b1;
            end
          end
          if (!found) failed = 1'b1;
        end
      end
    end
    for (int r = 0; r < MAX_UNKNOWNS; r++) cur[r] = '0;
    sweeps = 0;
    zp = 1'b0;
    for (int r = 0; r < n; r++) if (mat[r][r] == 0) zp = 1'b1;
    if (zp) begin
      st = jls_pkg::STATUS_ZERO_PIVOT;
    end else begin
      for (;;) begin
        for (int r = 0; r < n; r++) prv[r] = cur[r];
        ssq = '0;
        for (int r = 0; r < n; r++) begin
          acc = '0;
          for (int c = 0; c < n; c++) if (c != r) acc = acc + mat[r][c] * prv[c];
          num = mat[r][n];
          num = (num <<< 32) - acc;
          den = mat[r][r];
          q = num / den;
          if (q > 128'sd140737488355327) cur[r] = jls_pkg::VAL_MAX;
          else if (q < -128'sd140737488355328) cur[r] = jls_pkg::VAL_MIN;
          else cur[r] = q[VAL_W-1:0];
        end
        for (int r = 0; r < n; r++) begin
          diff = prv[r];
          diff = diff - cur[r];
          d = diff < 0 ? -diff : diff;
          ssq = ssq + 128'(d) * 128'(d);
        end
        sweeps++;
        if (ssq <= 128'(tol_reg)) begin
          st = jls_pkg::STATUS_CONVERGED;
          break;
        end
        if (sweeps >= lim) begin
          st = jls_pkg::STATUS_LIMIT;
          break;
        end
      end
    end
    for (int r = 0; r < n; r++) begin
      u.idx = 3'(r);
      u.val = cur[r];
      u.sweeps = 16'(sweeps);
      u.st = st;
      u.failed = failed;
      u.last = (r == n - 1);
      solution_q.push_back(u);
    end
    solves++;
  endfunction

  always @(posedge clk) begin
    unknown_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (solution_q.size() == 0) begin
        $error("result with nothing expected: unknown %0d", out_unknown_index);
        errors++;
      end else begin
        e = solution_q.pop_front();
        if (out_unknown_index !== e.idx) begin
          $error("unknown_index exp %0d got %0d", e.idx, out_unknown_index); errors++;
        end
        if (out_solution_value !== e.val) begin
          $error("solution_value exp %0d got %0d", e.val, out_solution_value); errors++;
        end
        if (out_sweep_count !== e.sweeps) begin
          $error("sweep_count exp %0d got %0d", e.sweeps, out_sweep_count); errors++;
        end
        if (out_status !== e.st) begin
          $error("status exp %0d got %0d", e.st, out_status); errors++;
        end
        if (out_reorder_failed !== e.failed) begin
          $error("reorder_failed exp %0d got %0d", e.failed, out_reorder_failed); errors++;
        end
        if (out_last_result !== e.last) begin
          $error("last_result exp %0d got %0d", e.last, out_last_result); errors++;
        end
      end
    end
  end

  task automatic send_element(input logic [2:0] row, input logic [3:0] col,
                              input logic signed [47:0] val, input logic done);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    in_row_index = row;
    in_column_index = col;
    in_element_value = val;
    in_load_done = done;
    do @(posedge clk); while (busy);
    items_sent++;
    if (col <= 4'(MAX_UNKNOWNS)) mat[row][col] = val;
    if (done) solve_system();
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (solution_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      jls_pkg::REG_SYSTEM_SIZE: size_reg = data[3:0];
      jls_pkg::REG_TOLERANCE:   tol_reg = data;
      jls_pkg::REG_ITER_LIMIT:  limit_reg = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [47:0] rand_full();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic logic signed [47:0] rand_small(int sh);
    logic signed [63:0] v;
    v = 64'($urandom) << $urandom_range(0, sh);
    if ($urandom_range(1)) v = -v;
    return v[47:0];
  endfunction

  // loads a full n by n+1 system in random order, with ignored items mixed in
  task automatic load_system(input int n, input bit wild, input bit diag_only);
    logic signed [47:0] a [0:MAX_UNKNOWNS-1][0:COLS-1];
    logic signed [63:0] s;
    int ord [0:MAX_UNKNOWNS*COLS-1];
    int cnt, j, tmp, r, c;
    bit ext_done;
    for (r = 0; r < n; r++) begin
      s = 0;
      for (c = 0; c < n; c++) begin
        if (c == r) continue;
        a[r][c] = wild ? rand_full() : (diag_only ? 48'sd0 : rand_small(1));
        s += absv(a[r][c]);
      end
      a[r][n] = wild ? rand_full() : rand_small(4);
      if (wild) begin
        a[r][r] = rand_full();
      end else begin
        s = s + (64'd1 << 32) + $urandom;
        a[r][r] = $urandom_range(1) ? s[47:0] : -s[47:0];
      end
    end
    cnt = n * (n + 1);
    for (int k = 0; k < cnt; k++) ord[k] = k;
    for (int k = cnt - 1; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = ord[k]; ord[k] = ord[j]; ord[j] = tmp;
    end
    ext_done = ($urandom_range(3) == 0);
    for (int k = 0; k < cnt; k++) begin
      if ($urandom_range(99) < 12) begin
        if (n < MAX_UNKNOWNS && $urandom_range(1))
          send_element(3'($urandom_range(MAX_UNKNOWNS - 1, n)), 4'($urandom_range(8)),
                       rand_full(), 1'b0);
        else
          send_element(3'($urandom), 4'($urandom_range(15, 9)), rand_full(), 1'b0);
      end
      r = ord[k] / (n + 1);
      c = ord[k] % (n + 1);
      send_element(3'(r), 4'(c), a[r][c], (k == cnt - 1) && !ext_done);
    end
    if (ext_done) send_element(3'($urandom), 4'($urandom_range(15, 9)), rand_full(), 1'b1);
  endtask

  task automatic test_directed();
    write_reg(jls_pkg::REG_SYSTEM_SIZE, 64'd1);
    // tiny pivot pushes the quotient past both range ends
    send_element(3'd0, 4'd0, 48'sd1, 1'b0);
    send_element(3'd0, 4'd1, jls_pkg::VAL_MAX, 1'b1);
    send_element(3'd0, 4'd1, jls_pkg::VAL_MIN, 1'b1);
    // zero pivot
    write_reg(jls_pkg::REG_SYSTEM_SIZE, 64'd2);
    for (int k = 0; k < 6; k++) send_element(3'(k / 3), 4'(k % 3), 48'sd0, k == 5);
    // dominance reached by swapping the rows
    send_element(3'd0, 4'd0, 48'sd1 <<< 32, 1'b0);
    send_element(3'd0, 4'd1, 48'sd5 <<< 32, 1'b0);
    send_element(3'd0, 4'd2, 48'sd3 <<< 32, 1'b0);
    send_element(3'd1, 4'd0, 48'sd5 <<< 32, 1'b0);
    send_element(3'd1, 4'd1, 48'sd1 <<< 32, 1'b0);
    send_element(3'd1, 4'd2, -(48'sd7 <<< 32), 1'b1);
    // no dominant partner row, single sweep from a zero limit
    write_reg(jls_pkg::REG_ITER_LIMIT, 64'd0);
    send_element(3'd0, 4'd0, 48'sd1 <<< 32, 1'b0);
    send_element(3'd0, 4'd1, 48'sd5 <<< 32, 1'b0);
    send_element(3'd1, 4'd0, 48'sd1 <<< 32, 1'b0);
    send_element(3'd1, 4'd1, 48'sd5 <<< 32, 1'b1);
    // size zero acts as one; ignored column carries the done flag
    write_reg(jls_pkg::REG_SYSTEM_SIZE, 64'd0);
    send_element(3'd7, 4'd15, rand_full(), 1'b1);
  endtask

  task automatic test_extremes();
    write_reg(jls_pkg::REG_SYSTEM_SIZE, 64'd15);
    write_reg(jls_pkg::REG_ITER_LIMIT, 64'd65535);
    write_reg(jls_pkg::REG_TOLERANCE, 64'd0);
    load_system(MAX_UNKNOWNS, 1'b0, 1'b1);
    // second solve on the stored system with a new right-hand side entry
    write_reg(jls_pkg::REG_TOLERANCE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(jls_pkg::REG_SYSTEM_SIZE, 64'd9);
    send_element(3'd0, 4'd8, rand_small(4), 1'b1);
  endtask

  task automatic test_random(input int pct, input logic [63:0] tol, input int lim);
    int n, base_items, base_solves;
    gap_pct = pct;
    write_reg(jls_pkg::REG_TOLERANCE, tol);
    write_reg(jls_pkg::REG_ITER_LIMIT, 64'(lim));
    base_items = items_sent;
    base_solves = solution_q.size() + results_seen;
    while (items_sent - base_items < 6 || solution_q.size() + results_seen - base_solves < 3)
    begin
      n = $urandom_range(1, 3);
      write_reg(jls_pkg::REG_SYSTEM_SIZE, 64'(n));
      load_system(n, $urandom_range(99) < 20, 1'b0);
    end
    gap_pct = 0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_extremes();
    test_random(16, 64'd18446744, 25);
    test_random(81, 64'd1 << 40, 20);
    test_random(0, 64'd0, 12);
    wait_idle();
    $display("tb: %0d element transfers, %0d solves, %0d results checked",
             items_sent, solves, results_seen);
    $display("tb: sizes 1..15, swaps, reorder failure, zero pivot, saturation, limit extremes");
    if (errors == 0 && solution_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: jacobi_linear_solver_unit.f
hdl/jls_pkg.sv
hdl/jls_mul.sv
hdl/jls_div.sv
hdl/jacobi_linear_solver_unit.sv
dv/tb.sv
